/* rtl/core/single_source_shortest_paths_unit_defines.svh */
// Assertion macros for the checker file of the shortest path unit.
`ifndef SINGLE_SOURCE_SHORTEST_PATHS_UNIT_DEFINES_SVH
`define SINGLE_SOURCE_SHORTEST_PATHS_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SSSP_ASSERT_IMP(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("sssp checker: property failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SSSP_ASSERT_NXT(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("sssp checker: property failed");

`endif

/* rtl/core/sssp_pkg.sv */
// Shared types and constants of the shortest path unit.
`default_nettype none

package sssp_pkg;

    localparam int DIST_W   = 22;
    localparam int VTX_W    = 6;
    localparam int VCOUNT_W = 7;

    localparam logic [DIST_W-1:0]   DIST_MAX      = {DIST_W{1'b1}};
    localparam logic [VCOUNT_W-1:0] VCOUNT_RESET  = 7'd64;
    localparam logic [VTX_W-1:0]    SOURCE_RESET  = 6'd0;

    // Register index, taken from paddr[2]
    localparam logic REG_VERTEX_COUNT = 1'b0;
    localparam logic REG_SOURCE       = 1'b1;

    typedef enum logic [1:0] {
        REQ_LOAD  = 2'd0,
        REQ_RUN   = 2'd1,
        REQ_CLEAR = 2'd2
    } req_t;

    // One vertex memory word
    typedef struct packed {
        logic [DIST_W-1:0] plen;
        logic              reached;
        logic              settled;
    } vtx_t;

endpackage

`default_nettype wire

/* rtl/core/single_source_shortest_paths_unit.sv */
// Shortest path unit: edge store, vertex memory and the search sequencer.
// A load, clear or unknown request is handled in the idle state and the unit
// stays ready for the next request. A run with n vertices and R reachable
// vertices first initializes the vertex memory, then runs R rounds that each
// scan all n vertices, settle the closest reached unsettled one and check every
// stored edge, then one final scan, then n results at one per cycle while the
// output side takes them. The round length comes from the single read port of
// the vertex memory: every vertex is scanned once per round to find the next
// one to settle, and each edge leaving the settled vertex that lands inside the
// graph costs an extra read-modify-write. Both memories start undefined; no
// clearing pass runs after reset.
`default_nettype none

module single_source_shortest_paths_unit
    import sssp_pkg::*;
#(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_EDGES    = 512,
    parameter int WEIGHT_BITS  = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // requests
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // edge_from[5:0], edge_to[11:6], edge_weight[27:12]
    input  wire logic [1:0]  s_tuser,   // req_type[1:0]
    // results
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata,   // vertex_index[5:0], path_length[27:6]
    output logic      [1:0]  m_tuser,   // reachable[0], edges_dropped[1]
    output logic             m_tlast
);

    localparam int VW  = $clog2(MAX_VERTICES);
    localparam int NW  = $clog2(MAX_VERTICES + 1);
    localparam int FW  = $clog2(MAX_EDGES + 1);
    localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int WK  = (WEIGHT_BITS < 16) ? WEIGHT_BITS : 16;
    localparam int SW  = ((WEIGHT_BITS > DIST_W) ? WEIGHT_BITS : DIST_W) + 1;

    typedef struct packed {
        logic [WEIGHT_BITS-1:0] wgt;
        logic [VTX_W-1:0]       eto;
        logic [VTX_W-1:0]       efrom;
    } edge_rec_t;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_INIT   = 7'b0000010,
        S_SCAN   = 7'b0000100,
        S_SETTLE = 7'b0001000,
        S_ECHK   = 7'b0010000,
        S_EUPD   = 7'b0100000,
        S_EMIT   = 7'b1000000
    } state_t;

    // memories
    edge_rec_t emem [MAX_EDGES];
    vtx_t      vmem [MAX_VERTICES];

    state_t              state_reg, state_next;
    logic [FW-1:0]       fill_reg, fill_next;
    logic                ovf_reg, ovf_next;
    logic [VCOUNT_W-1:0] vcount_reg, vcount_next;
    logic [VTX_W-1:0]    src_reg, src_next;
    logic [NW-1:0]       n_reg, n_next;
    logic [NW-1:0]       sa_reg, sa_next;
    logic                rdv_reg, rdv_next;
    logic [VW-1:0]       ridx_reg, ridx_next;
    logic                found_reg, found_next;
    logic [VW-1:0]       pick_reg, pick_next;
    logic [DIST_W-1:0]   best_reg, best_next;
    logic [FW-1:0]       e_reg, e_next;
    logic [NW-1:0]       ev_reg, ev_next;

    logic                ovalid_reg, ovalid_next;
    logic [VTX_W-1:0]    oidx_reg, oidx_next;
    logic [DIST_W-1:0]   olen_reg, olen_next;
    logic                oreach_reg, oreach_next;
    logic                odrop_reg, odrop_next;
    logic                olast_reg, olast_next;

    edge_rec_t           eq_reg;
    vtx_t                vq_reg;

    logic                s_accept;
    logic                cfg_write;
    req_t                req;
    logic [NW-1:0]       n_run;
    logic [WEIGHT_BITS-1:0] w_in;
    logic [SW-1:0]       sum;
    logic [DIST_W-1:0]   cand;

    logic                ewe;
    edge_rec_t           ewdata;
    logic [EAW-1:0]      eraddr;
    logic                vwe;
    logic [VW-1:0]       vwaddr;
    vtx_t                vwdata;
    logic [VW-1:0]       vraddr;

    assign s_tready  = (state_reg == S_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign req       = req_t'(s_tuser);
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_comb
    begin
        unique case (paddr[2])
            REG_VERTEX_COUNT: prdata = 32'(vcount_reg);
            REG_SOURCE:       prdata = 32'(src_reg);
            default:          prdata = '0;
        endcase
    end

    always_comb
    begin
        w_in = '0;
        w_in[WK-1:0] = s_tdata[12 +: WK];
    end

    always_comb
    begin
        if (vcount_reg == '0)
            n_run = NW'(1);
        else if (int'(vcount_reg) > MAX_VERTICES)
            n_run = NW'(MAX_VERTICES);
        else
            n_run = NW'(vcount_reg);
    end

    // relaxation candidate, saturated
    always_comb
    begin
        sum  = SW'(best_reg) + SW'(eq_reg.wgt);
        cand = (sum > SW'(DIST_MAX)) ? DIST_MAX : DIST_W'(sum);
    end

    assign ewdata = '{wgt: w_in, eto: s_tdata[11:6], efrom: s_tdata[5:0]};

    always_comb
    begin
        state_next  = state_reg;
        fill_next   = fill_reg;
        ovf_next    = ovf_reg;
        vcount_next = vcount_reg;
        src_next    = src_reg;
        n_next      = n_reg;
        sa_next     = sa_reg;
        rdv_next    = 1'b0;
        ridx_next   = ridx_reg;
        found_next  = found_reg;
        pick_next   = pick_reg;
        best_next   = best_reg;
        e_next      = e_reg;
        ev_next     = ev_reg;
        ovalid_next = ovalid_reg;
        oidx_next   = oidx_reg;
        olen_next   = olen_reg;
        oreach_next = oreach_reg;
        odrop_next  = odrop_reg;
        olast_next  = olast_reg;
        ewe         = 1'b0;
        eraddr      = e_reg[EAW-1:0];
        vwe         = 1'b0;
        vwaddr      = pick_reg;
        vwdata      = '{plen: best_reg, reached: 1'b1, settled: 1'b1};
        vraddr      = ev_reg[VW-1:0];

        if (cfg_write)
        begin
            unique case (paddr[2])
                REG_VERTEX_COUNT: vcount_next = pwdata[VCOUNT_W-1:0];
                REG_SOURCE:       src_next    = pwdata[VTX_W-1:0];
                default:          ;
            endcase
        end

        if (ovalid_reg && m_tready)
            ovalid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_accept)
                begin
                    case (req)
                        REQ_LOAD:
                        begin
                            if (int'(fill_reg) < MAX_EDGES)
                            begin
                                ewe       = 1'b1;
                                fill_next = fill_reg + 1'b1;
                            end
                            else
                                ovf_next = 1'b1;
                        end
                        REQ_CLEAR:
                        begin
                            fill_next = '0;
                            ovf_next  = 1'b0;
                        end
                        REQ_RUN:
                        begin
                            n_next     = n_run;
                            sa_next    = '0;
                            state_next = S_INIT;
                        end
                        default: ;
                    endcase
                end
            end

            S_INIT:
            begin
                vwe    = 1'b1;
                vwaddr = sa_reg[VW-1:0];
                vwdata = '{plen: '0, reached: (int'(sa_reg) == int'(src_reg)),
                           settled: 1'b0};
                if (sa_reg == n_reg - 1'b1)
                begin
                    sa_next    = '0;
                    found_next = 1'b0;
                    state_next = S_SCAN;
                end
                else
                    sa_next = sa_reg + 1'b1;
            end

            S_SCAN:
            begin
                // compare the word read last cycle
                if (rdv_reg && vq_reg.reached && !vq_reg.settled &&
                    (!found_reg || vq_reg.plen < best_reg))
                begin
                    found_next = 1'b1;
                    pick_next  = ridx_reg;
                    best_next  = vq_reg.plen;
                end
                if (sa_reg < n_reg)
                begin
                    vraddr    = sa_reg[VW-1:0];
                    rdv_next  = 1'b1;
                    ridx_next = sa_reg[VW-1:0];
                    sa_next   = sa_reg + 1'b1;
                end
                else if (!rdv_reg)
                begin
                    if (found_reg)
                        state_next = S_SETTLE;
                    else
                    begin
                        vraddr     = '0;
                        ev_next    = '0;
                        state_next = S_EMIT;
                    end
                end
            end

            S_SETTLE:
            begin
                vwe = 1'b1;
                if (fill_reg == '0)
                begin
                    sa_next    = '0;
                    found_next = 1'b0;
                    state_next = S_SCAN;
                end
                else
                begin
                    eraddr     = '0;
                    e_next     = '0;
                    state_next = S_ECHK;
                end
            end

            S_ECHK:
            begin
                if (int'(eq_reg.efrom) == int'(pick_reg) && int'(eq_reg.eto) < int'(n_reg))
                begin
                    vraddr     = VW'(eq_reg.eto);
                    state_next = S_EUPD;
                end
                else if (e_reg + 1'b1 < fill_reg)
                begin
                    e_next = e_reg + 1'b1;
                    eraddr = e_next[EAW-1:0];
                end
                else
                begin
                    sa_next    = '0;
                    found_next = 1'b0;
                    state_next = S_SCAN;
                end
            end

            S_EUPD:
            begin
                // vertex memory is idle otherwise in this cycle, so the write
                // lands before any later read of the same entry
                if (!vq_reg.reached || cand < vq_reg.plen)
                begin
                    vwe    = 1'b1;
                    vwaddr = VW'(eq_reg.eto);
                    vwdata = '{plen: cand, reached: 1'b1, settled: vq_reg.settled};
                end
                if (e_reg + 1'b1 < fill_reg)
                begin
                    e_next     = e_reg + 1'b1;
                    eraddr     = e_next[EAW-1:0];
                    state_next = S_ECHK;
                end
                else
                begin
                    sa_next    = '0;
                    found_next = 1'b0;
                    state_next = S_SCAN;
                end
            end

            S_EMIT:
            begin
                if (!ovalid_reg || m_tready)
                begin
                    ovalid_next = 1'b1;
                    oidx_next   = VTX_W'(ev_reg);
                    olen_next   = vq_reg.reached ? vq_reg.plen : '0;
                    oreach_next = vq_reg.reached;
                    odrop_next  = ovf_reg;
                    olast_next  = (ev_reg == n_reg - 1'b1);
                    if (ev_reg == n_reg - 1'b1)
                        state_next = S_IDLE;
                    else
                    begin
                        ev_next = ev_reg + 1'b1;
                        vraddr  = ev_next[VW-1:0];
                    end
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            fill_reg   <= '0;
            ovf_reg    <= 1'b0;
            vcount_reg <= VCOUNT_RESET;
            src_reg    <= SOURCE_RESET;
            n_reg      <= '0;
            sa_reg     <= '0;
            rdv_reg    <= 1'b0;
            ridx_reg   <= '0;
            found_reg  <= 1'b0;
            pick_reg   <= '0;
            best_reg   <= '0;
            e_reg      <= '0;
            ev_reg     <= '0;
            ovalid_reg <= 1'b0;
            oidx_reg   <= '0;
            olen_reg   <= '0;
            oreach_reg <= 1'b0;
            odrop_reg  <= 1'b0;
            olast_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            fill_reg   <= fill_next;
            ovf_reg    <= ovf_next;
            vcount_reg <= vcount_next;
            src_reg    <= src_next;
            n_reg      <= n_next;
            sa_reg     <= sa_next;
            rdv_reg    <= rdv_next;
            ridx_reg   <= ridx_next;
            found_reg  <= found_next;
            pick_reg   <= pick_next;
            best_reg   <= best_next;
            e_reg      <= e_next;
            ev_reg     <= ev_next;
            ovalid_reg <= ovalid_next;
            oidx_reg   <= oidx_next;
            olen_reg   <= olen_next;
            oreach_reg <= oreach_next;
            odrop_reg  <= odrop_next;
            olast_reg  <= olast_next;
        end
    end

    // edge store
    always_ff @(posedge clk)
    begin
        if (ewe)
            emem[fill_reg[EAW-1:0]] <= ewdata;
        eq_reg <= emem[eraddr];
    end

    // vertex memory
    always_ff @(posedge clk)
    begin
        if (vwe)
            vmem[vwaddr] <= vwdata;
        vq_reg <= vmem[vraddr];
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = {4'b0, olen_reg, oidx_reg};
    assign m_tuser  = {odrop_reg, oreach_reg};
    assign m_tlast  = olast_reg;

endmodule

`default_nettype wire

/* rtl/core/sssp_checker.sv */
// Port-level checker for the shortest path unit, bound to the top level.
`default_nettype none
`include "single_source_shortest_paths_unit_defines.svh"

module sssp_checker
    import sssp_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [1:0]  s_tuser,   // req_type[1:0]
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,   // vertex_index[5:0], path_length[27:6]
    input wire logic [1:0]  m_tuser,   // reachable[0], edges_dropped[1]
    input wire logic        m_tlast
);

    // a stalled result holds
    `SSSP_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

    // unreachable vertices report a zero length
    `SSSP_ASSERT_IMP(a_unreach_zero, m_tvalid && !m_tuser[0], m_tdata[27:6] == 22'd0)

    // loads, clears and unknown requests leave the request side ready
    `SSSP_ASSERT_NXT(a_short_req, s_tvalid && s_tready && (s_tuser != REQ_RUN), s_tready)

    // a run keeps the request side closed while it works
    `SSSP_ASSERT_NXT(a_run_busy, s_tvalid && s_tready && (s_tuser == REQ_RUN), !s_tready)

endmodule

bind single_source_shortest_paths_unit sssp_checker u_sssp_checker (.*);

`default_nettype wire
